FILE: rtl/dpf_pkg.sv
// Shared types and constants for the dedup packet FIFO with window count.
// No dependencies; imported by dpf_cell, dpf_tally and the core.
`timescale 1ns / 1ps

package dpf_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int OCC_W  = $clog2(DEPTH + 1);
   localparam int CAP_W  = 7;
   localparam int CNT_W  = 7;
   localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // count tally: hit bits are summed in groups, groups are summed a few lanes per step
   localparam int GROUP  = 8;
   localparam int GRP_W  = $clog2(GROUP + 1);
   localparam int NGRP   = (DEPTH + GROUP - 1) / GROUP;
   localparam int LANES  = 8;
   localparam int NSTEP  = (NGRP + LANES - 1) / LANES;
   localparam int NSLOT  = NSTEP * LANES;
   localparam int STEP_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;

   typedef logic [1:0] req_code_type;

   localparam req_code_type REQ_ADD   = 2'd0;
   localparam req_code_type REQ_FWD   = 2'd1;
   localparam req_code_type REQ_COUNT = 2'd2;
   localparam req_code_type REQ_NONE  = 2'd3;

   typedef struct packed {
      logic [15:0] source;
      logic [15:0] destination;
      logic [31:0] timestamp;
   } entry_type;

   typedef struct packed {
      entry_type   pkt;
      logic [31:0] window_start;
      logic [31:0] window_end;
   } key_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic count_mode;
   } cell_ctrl_type;

endpackage

FILE: rtl/dpf_cell.sv
// One FIFO slot: holds a packet and its valid bit, shifts toward the head, and
// registers a duplicate or window match against the broadcast key. Uses dpf_pkg.
`timescale 1ns / 1ps

module dpf_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  dpf_pkg::cell_ctrl_type ctrl,
   input  dpf_pkg::key_type      key,
   input  logic                  next_valid,
   input  dpf_pkg::entry_type    next_entry,
   output logic                  valid,
   output dpf_pkg::entry_type    entry,
   output logic                  hit
);
   import dpf_pkg::*;

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      hit_ff, hit_in;
   logic      dup_match;
   logic      win_match;

   always_comb begin
      dup_match = (entry_ff == key.pkt);
      win_match = (entry_ff.destination == key.pkt.destination) &&
                  (entry_ff.timestamp >= key.window_start) &&
                  (entry_ff.timestamp <= key.window_end);
      hit_in    = valid_ff && (ctrl.count_mode ? win_match : dup_match);

      valid_in = valid_ff;
      entry_in = entry_ff;
      if (ctrl.load) begin
         valid_in = 1'b1;
         entry_in = key.pkt;
      end else if (ctrl.shift) begin
         valid_in = next_valid;
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

FILE: rtl/dpf_tally.sv
// Match counter: popcounts the cells' hit bits per group, then sums the group
// counts a row of lanes per step while the group row shifts down. Uses dpf_pkg.
`timescale 1ns / 1ps

module dpf_tally (
   input  logic                      clock,
   input  logic                      start,
   input  logic                      step,
   input  logic [dpf_pkg::DEPTH-1:0] hits,
   output logic [dpf_pkg::CNT_W-1:0] total
);
   import dpf_pkg::*;

   logic [NSLOT*GROUP-1:0] hits_pad;
   logic [GRP_W-1:0]       grp_pop [NSLOT];
   logic [GRP_W-1:0]       grp_ff  [NSLOT];
   logic [GRP_W-1:0]       grp_in  [NSLOT];
   logic [CNT_W-1:0]       acc_ff, acc_in;
   logic [CNT_W-1:0]       lane_sum;

   always_comb begin
      hits_pad = (NSLOT*GROUP)'(hits);
      for (int g = 0; g < NSLOT; g++) begin
         grp_pop[g] = '0;
         for (int k = 0; k < GROUP; k++) begin
            grp_pop[g] = grp_pop[g] + GRP_W'(hits_pad[g*GROUP + k]);
         end
      end

      lane_sum = '0;
      for (int k = 0; k < LANES; k++) begin
         lane_sum = lane_sum + CNT_W'(grp_ff[k]);
      end

      // advance the group row by one step of lanes
      for (int j = 0; j < NSLOT - LANES; j++) begin
         grp_in[j] = step ? grp_ff[j + LANES] : grp_ff[j];
      end
      for (int j = NSLOT - LANES; j < NSLOT; j++) begin
         grp_in[j] = step ? '0 : grp_ff[j];
      end
      acc_in = step ? acc_ff + lane_sum : acc_ff;

      if (start) begin
         for (int j = 0; j < NSLOT; j++) begin
            grp_in[j] = grp_pop[j];
         end
         acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
      acc_ff <= acc_in;
   end

   assign total = acc_ff;

endmodule

FILE: rtl/dedup_packet_fifo_with_window_count_core.sv
// Top level of the dedup packet FIFO with window count: request sequencer,
// chain of dpf_cell slots, dpf_tally counter and result register. Uses dpf_pkg.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------------------
//   req      | in        | req_valid/req_ready  | type, source, destination, timestamp, window
//   rsp      | out       | rsp_valid/rsp_ready  | ok, packet fields, match_count
//   csr      | in        | csr_wr_en            | capacity (7 bits)
//
// States from request accept: forward and unknown go straight to the final state, add
// compares first, count compares, loads the group tally and sums its steps first.
// All slots compare in parallel; the FIFO shifts toward slot 0.
// Reset is synchronous; it clears valid bits, occupancy and capacity (to 64).
// A new request is taken while a result waits; the sequencer holds in its
// final state until the result register is free.
`timescale 1ns / 1ps

module dedup_packet_fifo_with_window_count_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_type,
   input  logic [15:0]               req_source,
   input  logic [15:0]               req_destination,
   input  logic [31:0]               req_timestamp,
   input  logic [31:0]               req_window_start,
   input  logic [31:0]               req_window_end,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_ok,
   output logic [15:0]               rsp_out_source,
   output logic [15:0]               rsp_out_destination,
   output logic [31:0]               rsp_out_timestamp,
   output logic [dpf_pkg::CNT_W-1:0] rsp_match_count,
   input  logic                      csr_wr_en,
   input  logic [dpf_pkg::CAP_W-1:0] csr_wr_data
);
   import dpf_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_CMP, S_GRP, S_SUM, S_FIN} state_type;

   state_type        state_ff, state_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   req_code_type     kind_ff, kind_in;
   key_type          key_ff, key_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ok_ff, rsp_ok_in;
   entry_type        rsp_pkt_ff, rsp_pkt_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [DEPTH-1:0] cell_valid;
   entry_type        cell_entry [DEPTH];
   logic [DEPTH-1:0] hit_vec;
   cell_ctrl_type    cell_ctrl  [DEPTH];

   logic [CNT_W-1:0] total;
   logic             req_fire;
   logic             fin_go;
   logic             dup;
   logic             add_ok;
   logic             fwd_ok;
   logic             evict;
   logic [CMP_W-1:0] eff_cap;
   logic [OCC_W-1:0] occ_sel;
   logic [IDX_W-1:0] wr_idx;

   always_comb begin
      req_ready = (state_ff == S_IDLE);
      req_fire  = req_valid && req_ready;
      fin_go    = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);
      dup       = |hit_vec;

      // capacity of zero acts as one, above the slot count as the slot count
      eff_cap = CMP_W'(cap_ff);
      if (eff_cap == '0) begin
         eff_cap = CMP_W'(1);
      end
      if (eff_cap > CMP_W'(DEPTH)) begin
         eff_cap = CMP_W'(DEPTH);
      end
      evict   = (CMP_W'(occ_ff) >= eff_cap) && (occ_ff != '0);
      occ_sel = evict ? occ_ff - OCC_W'(1) : occ_ff;
      wr_idx  = occ_sel[IDX_W-1:0];

      add_ok = (kind_ff == REQ_ADD) && !dup;
      fwd_ok = (kind_ff == REQ_FWD) && (occ_ff != '0) && cell_valid[0];
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_chain
      logic      nxt_valid;
      entry_type nxt_entry;

      if (i == DEPTH - 1) begin : g_tail
         assign nxt_valid = 1'b0;
         assign nxt_entry = '0;
      end else begin : g_mid
         assign nxt_valid = cell_valid[i+1];
         assign nxt_entry = cell_entry[i+1];
      end

      assign cell_ctrl[i].load       = fin_go && add_ok && (wr_idx == IDX_W'(i));
      assign cell_ctrl[i].shift      = fin_go && ((add_ok && evict) || fwd_ok);
      assign cell_ctrl[i].count_mode = (kind_ff == REQ_COUNT);

      dpf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl[i]),
         .key        (key_ff),
         .next_valid (nxt_valid),
         .next_entry (nxt_entry),
         .valid      (cell_valid[i]),
         .entry      (cell_entry[i]),
         .hit        (hit_vec[i])
      );
   end

   dpf_tally u_tally (
      .clock (clock),
      .start (state_ff == S_GRP),
      .step  (state_ff == S_SUM),
      .hits  (hit_vec),
      .total (total)
   );

   always_comb begin
      state_in     = state_ff;
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      occ_in       = occ_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_pkt_in   = rsp_pkt_ff;
      rsp_count_in = rsp_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in                  = req_type;
               key_in.pkt.source        = req_source;
               key_in.pkt.destination   = req_destination;
               key_in.pkt.timestamp     = req_timestamp;
               key_in.window_start      = req_window_start;
               key_in.window_end        = req_window_end;
               case (req_type) inside
                  REQ_FWD, REQ_NONE: state_in = S_FIN;
                  default:           state_in = S_CMP;
               endcase
            end
         end
         S_CMP: begin
            state_in = (kind_ff == REQ_COUNT) ? S_GRP : S_FIN;
         end
         S_GRP: begin
            step_in  = '0;
            state_in = S_SUM;
         end
         S_SUM: begin
            if (step_ff == STEP_W'(NSTEP - 1)) begin
               state_in = S_FIN;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_FIN: begin
            if (fin_go) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_pkt_in   = '0;
               rsp_count_in = '0;
               case (kind_ff)
                  REQ_ADD: begin
                     rsp_ok_in = add_ok;
                     if (add_ok && !evict) begin
                        occ_in = occ_ff + OCC_W'(1);
                     end
                  end
                  REQ_FWD: begin
                     if (fwd_ok) begin
                        rsp_ok_in  = 1'b1;
                        rsp_pkt_in = cell_entry[0];
                        occ_in     = occ_ff - OCC_W'(1);
                     end
                  end
                  REQ_COUNT: rsp_count_in = total;
                  default:   rsp_ok_in = 1'b0;
               endcase
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      key_ff       <= key_in;
      step_ff      <= step_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_pkt_ff   <= rsp_pkt_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ok              = rsp_ok_ff;
   assign rsp_out_source      = rsp_pkt_ff.source;
   assign rsp_out_destination = rsp_pkt_ff.destination;
   assign rsp_out_timestamp   = rsp_pkt_ff.timestamp;
   assign rsp_match_count     = rsp_count_ff;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for dedup_packet_fifo_with_window_count_core.
// Holds its own copy of the FIFO and checks each response against it.
// Depends on rtl/dpf_pkg.sv and the core RTL only.
`timescale 1ns / 1ps

module tb_top;
   import dpf_pkg::*;

   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 12;
   localparam int IDLE_LIMIT    = 5000;

   typedef struct packed {
      logic             ok;
      entry_type        pkt;
      logic [CNT_W-1:0] count;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             req_valid        = 1'b0;
   logic             req_ready;
   req_code_type     req_type         = REQ_NONE;
   logic [15:0]      req_source       = '0;
   logic [15:0]      req_destination  = '0;
   logic [31:0]      req_timestamp    = '0;
   logic [31:0]      req_window_start = '0;
   logic [31:0]      req_window_end   = '0;
   logic             rsp_valid;
   logic             rsp_ready        = 1'b0;
   logic             rsp_ok;
   logic [15:0]      rsp_out_source;
   logic [15:0]      rsp_out_destination;
   logic [31:0]      rsp_out_timestamp;
   logic [CNT_W-1:0] rsp_match_count;
   logic             csr_wr_en        = 1'b0;
   logic [CAP_W-1:0] csr_wr_data      = '0;

   // model of the block
   entry_type        held[$];
   logic [CAP_W-1:0] capacity_reg = CAP_RESET;
   outcome_type      pending_results[$];

   int error_count     = 0;
   int results_checked = 0;
   int kind_count[4]   = '{default: 0};
   int burst_left      = 0;
   bit sender_steady   = 1'b0;
   int hold_requests   = 0;
   logic [31:0] ts_clock = 32'h7FFF_FF00;
   logic [15:0] dest_pool[4] = '{16'h0000, 16'h0A0A, 16'h8001, 16'hFFFF};
   logic [15:0] src_pool[4]  = '{16'h0001, 16'h00F0, 16'hFF00, 16'h7FFF};

   dedup_packet_fifo_with_window_count_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_source          (req_source),
      .req_destination     (req_destination),
      .req_timestamp       (req_timestamp),
      .req_window_start    (req_window_start),
      .req_window_end      (req_window_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_ok              (rsp_ok),
      .rsp_out_source      (rsp_out_source),
      .rsp_out_destination (rsp_out_destination),
      .rsp_out_timestamp   (rsp_out_timestamp),
      .rsp_match_count     (rsp_match_count),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   always #1 clock = ~clock;

   function automatic int capacity_in_force();
      int c;
      c = int'(capacity_reg);
      if (c == 0) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
   endfunction

   // Apply one request to the FIFO model and return the response it must give.
   function automatic outcome_type apply_request(req_code_type kind, entry_type pkt,
                                                 logic [31:0] ws, logic [31:0] we);
      outcome_type r;
      bit dup;
      int n;
      r = '0;
      dup = 1'b0;
      n = 0;
      case (kind)
         REQ_ADD: begin
            foreach (held[i]) if (held[i] == pkt) dup = 1'b1;
            if (!dup) begin
               if (held.size() >= capacity_in_force() && held.size() > 0)
                  void'(held.pop_front());
               if (held.size() < DEPTH) held.insert(held.size(), pkt);
               r.ok = 1'b1;
            end
         end
         REQ_FWD: begin
            if (held.size() > 0) begin
               r.ok  = 1'b1;
               r.pkt = held.pop_front();
            end
         end
         REQ_COUNT: begin
            foreach (held[i])
               if (held[i].destination == pkt.destination &&
                   held[i].timestamp >= ws && held[i].timestamp <= we) n++;
            r.count = n[CNT_W-1:0];
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      error_count++;
      $display("[%0t] response %0d %s: expected %0h, got %0h",
               $realtime, results_checked, what, want, got);
   endtask

   // Offer one request; hold valid and payload until it is taken.
   task automatic send_request(req_code_type kind, entry_type pkt,
                               logic [31:0] ws, logic [31:0] we);
      int gap;
      if (!sender_steady) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_source       <= pkt.source;
      req_destination  <= pkt.destination;
      req_timestamp    <= pkt.timestamp;
      req_window_start <= ws;
      req_window_end   <= we;
      do @(posedge clock); while (!req_ready);
      kind_count[kind]++;
      pending_results.insert(pending_results.size(), apply_request(kind, pkt, ws, we));
   endtask

   task automatic add_packet(logic [15:0] src, logic [15:0] dst, logic [31:0] ts);
      send_request(REQ_ADD, '{source: src, destination: dst, timestamp: ts}, '0, '0);
   endtask

   task automatic count_window(logic [15:0] dst, logic [31:0] ws, logic [31:0] we);
      send_request(REQ_COUNT, '{source: '0, destination: dst, timestamp: '0}, ws, we);
   endtask

   task automatic forward_oldest();
      send_request(REQ_FWD, '0, '0, '0);
   endtask

   // Stop offering and wait until every response is back and the block settles.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      capacity_reg = value;
   endtask

   task automatic send_random_request();
      entry_type   pkt;
      logic [31:0] ws;
      logic [31:0] we;
      int          pick;
      pick = $urandom_range(0, 99);
      pkt  = '0;
      ws   = '0;
      we   = '0;
      if (pick < 50) begin
         if (held.size() > 0 && $urandom_range(0, 4) == 0) begin
            pkt = held[$urandom_range(0, held.size() - 1)];
         end else if ($urandom_range(0, 9) == 0) begin
            pkt = {$urandom, $urandom};
         end else begin
            ts_clock += $urandom_range(0, 3);
            pkt.source      = src_pool[$urandom_range(0, 3)];
            pkt.destination = dest_pool[$urandom_range(0, 3)];
            pkt.timestamp   = ts_clock;
         end
         send_request(REQ_ADD, pkt, ws, we);
      end else if (pick < 70) begin
         forward_oldest();
      end else if (pick < 95) begin
         if (held.size() > 0 && $urandom_range(0, 4) < 3)
            pkt.destination = held[$urandom_range(0, held.size() - 1)].destination;
         else
            pkt.destination = dest_pool[$urandom_range(0, 3)];
         case ($urandom_range(0, 9))
            0: begin
               ws = $urandom;
               we = $urandom;
            end
            1: begin
               ws = ts_clock - $urandom_range(0, 20);
               we = ws - $urandom_range(1, 20);
            end
            2: we = 32'hFFFF_FFFF;
            default: begin
               ws = ts_clock - $urandom_range(0, 60);
               we = ws + $urandom_range(0, 60);
            end
         endcase
         send_request(REQ_COUNT, pkt, ws, we);
      end else begin
         send_request(REQ_NONE, {$urandom, $urandom}, $urandom, $urandom);
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      forward_oldest();
      count_window(16'h0000, 32'h0, 32'hFFFF_FFFF);
      send_request(REQ_NONE, '0, '0, '0);
      add_packet(16'h0000, 16'h0000, 32'h0000_0000);
      add_packet(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      add_packet(16'h0000, 16'h0000, 32'h0000_0000);
      add_packet(16'h0000, 16'h0000, 32'h0000_0001);
      add_packet(16'h0001, 16'h0000, 32'h0000_0000);
      count_window(16'h0000, 32'h0, 32'hFFFF_FFFF);
      count_window(16'h0000, 32'h1, 32'h1);
      count_window(16'h0000, 32'h1, 32'h0);
      count_window(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      count_window(16'h0000, 32'h0, 32'h0);
      send_request(REQ_NONE, {16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}, 32'hFFFF_FFFF, '0);
      forward_oldest();
      add_packet(16'h0000, 16'h0000, 32'h0000_0000);
      repeat (5) forward_oldest();
   endtask

   task automatic test_capacity();
      write_capacity(7'd2);
      add_packet(16'h0010, 16'h0A0A, 32'd100);
      add_packet(16'h0011, 16'h0A0A, 32'd101);
      add_packet(16'h0012, 16'h0A0A, 32'd102);
      count_window(16'h0A0A, 32'd0, 32'd200);
      repeat (3) forward_oldest();
      // zero acts as one
      write_capacity(7'd0);
      add_packet(16'h0020, 16'h0001, 32'd5);
      add_packet(16'h0021, 16'h0001, 32'd6);
      repeat (2) forward_oldest();
      // fill, then lower the capacity below the occupancy: an add evicts one while full
      write_capacity(7'd127);
      for (int i = 0; i < 10; i++) add_packet(16'h0030, 16'h0002, 32'd1000 + i);
      write_capacity(7'd3);
      add_packet(16'h0031, 16'h0002, 32'd2000);
      count_window(16'h0002, 32'd0, 32'hFFFF_FFFF);
      repeat (8) forward_oldest();
      add_packet(16'h0032, 16'h0002, 32'd2001);
      add_packet(16'h0033, 16'h0002, 32'd2002);
      add_packet(16'h0033, 16'h0002, 32'd2002);
      count_window(16'h0002, 32'd0, 32'hFFFF_FFFF);
      repeat (4) forward_oldest();
   endtask

   task automatic test_fill_and_evict();
      write_capacity(7'd64);
      for (int i = 0; i < 70; i++)
         add_packet(16'(16'h0040 + i), 16'h0A0A, 32'd5000 + i);
      count_window(16'h0A0A, 32'h0, 32'hFFFF_FFFF);
      count_window(16'h0A0A, 32'd5010, 32'd5020);
      repeat (3) forward_oldest();
   endtask

   task automatic test_backpressure();
      drain();
      hold_requests++;
      sender_steady = 1'b1;
      repeat (30) send_random_request();
      sender_steady = 1'b0;
      drain();
   endtask

   task automatic test_random();
      logic [CAP_W-1:0] caps[9];
      caps = '{7'd64, 7'd1, 7'd8, 7'd127, 7'd0, 7'd3, 7'd100, 7'd16, 7'd64};
      caps[7] = 7'($urandom_range(1, 64));
      foreach (caps[p]) begin
         write_capacity(caps[p]);
         sender_steady = (p % 3 == 1);
         repeat (45) send_random_request();
      end
      sender_steady = 1'b0;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_capacity();
      test_fill_and_evict();
      test_backpressure();
      test_random();
      drain();
      if (pending_results.size() != 0)
         report_mismatch("requests left without a response", '0,
                         64'(pending_results.size()));
      $display("Covered %0d adds, %0d forwards, %0d counts, %0d unknown requests;",
               kind_count[REQ_ADD], kind_count[REQ_FWD], kind_count[REQ_COUNT],
               kind_count[REQ_NONE]);
      $display("%0d responses checked across several capacity settings, %0d mismatches.",
               results_checked, error_count);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Receiver: random stall patterns plus one long hold-off on request.
   int hold_served = 0;
   int hold_left   = 0;
   int stall_mode  = 0;
   int mode_left   = 0;
   int stall_phase = 0;

   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      stall_phase++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 1);
            default: rsp_ready <= ((stall_phase % 7) > 2);
         endcase
      end
   end

   // Check each response against the oldest outstanding prediction.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response with no request outstanding", '0, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ok !== want.ok)
               report_mismatch("ok", 64'(want.ok), 64'(rsp_ok));
            if (rsp_out_source !== want.pkt.source)
               report_mismatch("out_source", 64'(want.pkt.source), 64'(rsp_out_source));
            if (rsp_out_destination !== want.pkt.destination)
               report_mismatch("out_destination", 64'(want.pkt.destination),
                               64'(rsp_out_destination));
            if (rsp_out_timestamp !== want.pkt.timestamp)
               report_mismatch("out_timestamp", 64'(want.pkt.timestamp),
                               64'(rsp_out_timestamp));
            if (rsp_match_count !== want.count)
               report_mismatch("match_count", 64'(want.count), 64'(rsp_match_count));
         end
         results_checked++;
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timeout after %0d cycles without a handshake", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

endmodule
